// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the combiner RTL.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// cons must hold at the same edge whenever ante holds
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// cond must never hold
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`else

`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

// ----- hdl/tbdc_pkg.sv -----
// Package for the two-branch diversity combiner: widths, codes, shared types.
// No dependencies.
package tbdc_pkg;

    localparam int SAMPLE_W    = 16;   // Q1.15 samples
    localparam int GAIN_W      = 16;   // Q4.12 power gains
    localparam int SNR_W       = 16;   // Q8.8 linear SNR
    localparam int WEIGHT_FRAC = 15;
    localparam int WEIGHT_W    = WEIGHT_FRAC + 1;   // holds 1.0 exactly
    localparam int PROD_W      = GAIN_W + SNR_W;    // gain * snr
    localparam int DEN_W       = PROD_W + 1;        // a + b
    localparam int REM_W       = DEN_W + 1;         // shifted partial remainder
    localparam int CNT_W       = $clog2(WEIGHT_W);

    localparam logic [WEIGHT_W-1:0] WEIGHT_HALF = {2'b01, {(WEIGHT_W-2){1'b0}}};
    localparam logic [SNR_W-1:0]    SNR_RESET   = SNR_W'(256);

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // APB register port
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;
    localparam int IDX_W  = ADDR_W - 2;

    typedef enum logic [IDX_W-1:0] {
        REG_PER_SAMPLE = 3'd0,
        REG_EQUAL_GAIN = 3'd1,
        REG_SD_SNR     = 3'd2,
        REG_RD_SNR     = 3'd3,
        REG_RELAY_X4   = 3'd4
    } cfg_reg_t;

    // What the back end does with one item
    typedef enum logic [2:0] {
        OP_PASS        = 3'd0,   // relay only, pass the relay sample through
        OP_COMPUTE     = 3'd1,   // per-sample weights, state untouched
        OP_LATCH       = 3'd2,   // packet start, computed weights latched
        OP_LATCH_EQUAL = 3'd3,   // packet start, 0.5/0.5 latched
        OP_HELD        = 3'd4    // held weights and gain
    } op_t;

    typedef struct packed {
        logic              per_sample;
        logic              equal_gain;
        logic [SNR_W-1:0]  sd_snr;
        logic [SNR_W-1:0]  rd_snr;
        logic              relay_x4;
    } cfg_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] src_re;
        logic signed [SAMPLE_W-1:0] src_im;
        logic signed [SAMPLE_W-1:0] relay_re;
        logic signed [SAMPLE_W-1:0] relay_im;
        logic [GAIN_W-1:0]          sd_gain;
        logic [GAIN_W-1:0]          rd_gain;
    } item_t;

    typedef struct packed {
        op_t   op;
        item_t item;
    } entry_t;

    typedef struct packed {
        logic valid;
        logic full;
    } q_stat_t;

    typedef struct packed {
        logic             start;
        logic [DEN_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    typedef struct packed {
        logic idle;
        logic wait_div;
    } back_stat_t;

endpackage

// ----- hdl/tbdc_in_if.sv -----
// Input channel of the combiner: valid/ready plus one sample pair and gains.
// Depends on tbdc_pkg.
interface tbdc_in_if
    import tbdc_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] src_re;
    logic signed [SAMPLE_W-1:0] src_im;
    logic signed [SAMPLE_W-1:0] relay_re;
    logic signed [SAMPLE_W-1:0] relay_im;
    logic [GAIN_W-1:0]          sd_gain;
    logic [GAIN_W-1:0]          rd_gain;
    logic                       first_of_packet;
    logic                       relay_only;

    modport source (
        output valid, src_re, src_im, relay_re, relay_im, sd_gain, rd_gain,
               first_of_packet, relay_only,
        input  ready
    );

    modport sink (
        input  valid, src_re, src_im, relay_re, relay_im, sd_gain, rd_gain,
               first_of_packet, relay_only,
        output ready
    );
endinterface

// ----- hdl/tbdc_out_if.sv -----
// Output channel of the combiner: valid/ready plus combined sample and gain.
// Depends on tbdc_pkg.
interface tbdc_out_if
    import tbdc_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] out_re;
    logic signed [SAMPLE_W-1:0] out_im;
    logic [GAIN_W-1:0]          combined_gain;

    modport source (
        output valid, out_re, out_im, combined_gain,
        input  ready
    );

    modport sink (
        input  valid, out_re, out_im, combined_gain,
        output ready
    );
endinterface

// ----- hdl/tbdc_div.sv -----
// Restoring divider for branch weights: floor(num * 2^15 / den), num <= den.
// One quotient bit per cycle. Depends on tbdc_pkg.
module tbdc_div
    import tbdc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  div_req_t            req,
    input  logic [PROD_W-1:0]   num,
    output div_stat_t           stat,
    output logic [WEIGHT_W-1:0] quot
);

    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [REM_W-1:0]    rem_reg, rem_next;
    logic [DEN_W-1:0]    den_reg;
    logic [WEIGHT_W-1:0] quot_reg, quot_next;
    logic [REM_W-1:0]    trial;
    logic                ge;

    // first step yields the integer bit (num <= den), later steps shift in zeros
    assign trial = (cnt_reg == '0) ? rem_reg : {rem_reg[REM_W-2:0], 1'b0};
    assign ge    = trial >= {1'b0, den_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quot_next = quot_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = REM_W'(num);
            quot_next = '0;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? trial - {1'b0, den_reg} : trial;
            quot_next = {quot_reg[WEIGHT_W-2:0], ge};
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(WEIGHT_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        if (req.start)
        begin
            den_reg <= req.den;
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quot      = quot_reg;

endmodule

// ----- hdl/tbdc_queue.sv -----
// Short FIFO of classified items between the front end and the back end.
// Depends on tbdc_pkg.
module tbdc_queue
    import tbdc_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  entry_t  push_entry,
    input  logic    pop,
    output entry_t  pop_entry,
    output q_stat_t stat
);

    entry_t            mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    assign pop_entry  = mem_reg[rd_ptr_reg];
    assign stat.valid = count_reg != '0;
    assign stat.full  = count_reg == (QPTR_W + 1)'(QUEUE_DEPTH);

endmodule

// ----- hdl/tbdc_front.sv -----
// Front end: takes input items and tags each with the operation it needs.
// Depends on tbdc_pkg and tbdc_in_if.
module tbdc_front
    import tbdc_pkg::*;
(
    input  cfg_t       cfg,
    input  q_stat_t    q_stat,
    output logic       q_push,
    output entry_t     q_entry,
    tbdc_in_if.sink    in_ch
);

    op_t op;

    always_comb
    begin
        priority if (in_ch.relay_only)
        begin
            op = OP_PASS;
        end
        else if (cfg.per_sample)
        begin
            op = OP_COMPUTE;
        end
        else if (in_ch.first_of_packet)
        begin
            op = cfg.equal_gain ? OP_LATCH_EQUAL : OP_LATCH;
        end
        else
        begin
            op = OP_HELD;
        end
    end

    assign in_ch.ready = !q_stat.full;
    assign q_push      = in_ch.valid && !q_stat.full;

    assign q_entry.op            = op;
    assign q_entry.item.src_re   = in_ch.src_re;
    assign q_entry.item.src_im   = in_ch.src_im;
    assign q_entry.item.relay_re = in_ch.relay_re;
    assign q_entry.item.relay_im = in_ch.relay_im;
    assign q_entry.item.sd_gain  = in_ch.sd_gain;
    assign q_entry.item.rd_gain  = in_ch.rd_gain;

endmodule

// ----- hdl/tbdc_back.sv -----
// Back end: sequencer that computes weights, combined gain and the weighted sum,
// holds the packet weights and owns the output register. Depends on tbdc_pkg.
module tbdc_back
    import tbdc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  cfg_t                cfg,
    input  q_stat_t             q_stat,
    input  entry_t              q_entry,
    output logic                q_pop,
    output div_req_t            div_req,
    output logic [PROD_W-1:0]   div_num_a,
    output logic [PROD_W-1:0]   div_num_b,
    input  div_stat_t           div_stat,
    input  logic [WEIGHT_W-1:0] div_quot_a,
    input  logic [WEIGHT_W-1:0] div_quot_b,
    output back_stat_t          stat,
    tbdc_out_if.source          out_ch
);

    localparam int GP_W  = WEIGHT_W + GAIN_W;          // weight * gain
    localparam int GSH_W = GP_W + 1 - WEIGHT_FRAC;     // gain sum after shift
    localparam int MUL_W = SAMPLE_W + WEIGHT_W + 1;    // sample * signed weight
    localparam int ACC_W = MUL_W + 3;                  // with x4 and the add
    localparam int Q_W   = ACC_W - WEIGHT_FRAC;
    localparam logic signed [Q_W-1:0] Q_MAX = Q_W'((64'sd1 <<< (SAMPLE_W - 1)) - 64'sd1);
    localparam logic signed [Q_W-1:0] Q_MIN = -Q_MAX - Q_W'(1);

    typedef enum logic [12:0] {
        S_IDLE     = 13'b0000000000001,
        S_MUL_A    = 13'b0000000000010,
        S_MUL_B    = 13'b0000000000100,
        S_SUM      = 13'b0000000001000,
        S_DIV_GO   = 13'b0000000010000,
        S_DIV      = 13'b0000000100000,
        S_GAIN_A   = 13'b0000001000000,
        S_GAIN_B   = 13'b0000010000000,
        S_GAIN_SUM = 13'b0000100000000,
        S_SAMP_A   = 13'b0001000000000,
        S_SAMP_B   = 13'b0010000000000,
        S_SAMP_SUM = 13'b0100000000000,
        S_OUT      = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;

    op_t                        op_reg;
    item_t                      item_reg;
    logic [PROD_W-1:0]          a_reg, b_reg;
    logic [DEN_W-1:0]           d_reg;
    logic [WEIGHT_W-1:0]        w1_reg, w2_reg, w1_next, w2_next;
    logic                       w_load;
    logic [GP_W-1:0]            pg1_reg, pg2_reg;
    logic [GAIN_W-1:0]          gain_reg;
    logic signed [MUL_W-1:0]    m_re_reg, m_im_reg, n_re_reg, n_im_reg;
    logic signed [SAMPLE_W-1:0] res_re_reg, res_im_reg;
    logic [GAIN_W-1:0]          res_gain_reg;

    logic [WEIGHT_W-1:0]        held_w1_reg, held_w2_reg;
    logic [GAIN_W-1:0]          held_gain_reg;

    logic                       out_valid_reg, out_valid_next;
    logic signed [SAMPLE_W-1:0] out_re_reg, out_im_reg;
    logic [GAIN_W-1:0]          out_gain_reg;
    logic                       load_out;

    logic [GP_W:0]              gsum;
    logic [GSH_W-1:0]           gsh;
    logic [GAIN_W-1:0]          gain_sat;
    logic                       latch_op;

    // round half up from Q6.30 to Q1.15 and clip to the sample range
    function automatic logic signed [SAMPLE_W-1:0] round_sat(
        input logic signed [ACC_W-1:0] s
    );
        logic signed [ACC_W-1:0] biased;
        logic signed [Q_W-1:0]   q;
        biased = s + $signed({{(ACC_W - WEIGHT_W){1'b0}}, WEIGHT_HALF});
        q      = biased[ACC_W-1:WEIGHT_FRAC];
        if (q > Q_MAX)
        begin
            q = Q_MAX;
        end
        else if (q < Q_MIN)
        begin
            q = Q_MIN;
        end
        return q[SAMPLE_W-1:0];
    endfunction

    function automatic logic signed [ACC_W-1:0] relay_term(
        input logic signed [MUL_W-1:0] n,
        input logic                    x4
    );
        logic signed [ACC_W-1:0] e;
        e = ACC_W'(n);
        return x4 ? (e <<< 2) : e;
    endfunction

    assign q_pop    = (state_reg == S_IDLE) && q_stat.valid;
    assign load_out = (state_reg == S_OUT) && (!out_valid_reg || out_ch.ready);
    assign latch_op = (op_reg == OP_LATCH) || (op_reg == OP_LATCH_EQUAL);

    assign gsum     = {1'b0, pg1_reg} + {1'b0, pg2_reg};
    assign gsh      = gsum[GP_W:WEIGHT_FRAC];
    assign gain_sat = (|gsh[GSH_W-1:GAIN_W]) ? '1 : gsh[GAIN_W-1:0];

    assign div_req.start = (state_reg == S_DIV_GO) && (d_reg != '0);
    assign div_req.den   = d_reg;
    assign div_num_a     = a_reg;
    assign div_num_b     = b_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (q_stat.valid)
                begin
                    unique case (q_entry.op)
                        OP_PASS:        state_next = S_OUT;
                        OP_COMPUTE:     state_next = S_MUL_A;
                        OP_LATCH:       state_next = S_MUL_A;
                        OP_LATCH_EQUAL: state_next = S_GAIN_A;
                        OP_HELD:        state_next = S_SAMP_A;
                        default:        state_next = S_IDLE;
                    endcase
                end
            end
            S_MUL_A:    state_next = S_MUL_B;
            S_MUL_B:    state_next = S_SUM;
            S_SUM:      state_next = S_DIV_GO;
            S_DIV_GO:   state_next = (d_reg == '0) ? S_GAIN_A : S_DIV;
            S_DIV:      state_next = div_stat.done ? S_GAIN_A : S_DIV;
            S_GAIN_A:   state_next = S_GAIN_B;
            S_GAIN_B:   state_next = S_GAIN_SUM;
            S_GAIN_SUM: state_next = S_SAMP_A;
            S_SAMP_A:   state_next = S_SAMP_B;
            S_SAMP_B:   state_next = S_SAMP_SUM;
            S_SAMP_SUM: state_next = S_OUT;
            S_OUT:      state_next = load_out ? S_IDLE : S_OUT;
            default:    state_next = S_IDLE;
        endcase
    end

    // weight register sources
    always_comb
    begin
        w_load  = 1'b1;
        w1_next = w1_reg;
        w2_next = w2_reg;
        priority if (q_pop && (q_entry.op == OP_LATCH_EQUAL))
        begin
            w1_next = WEIGHT_HALF;
            w2_next = WEIGHT_HALF;
        end
        else if (q_pop && (q_entry.op == OP_HELD))
        begin
            w1_next = held_w1_reg;
            w2_next = held_w2_reg;
        end
        else if ((state_reg == S_DIV_GO) && (d_reg == '0))
        begin
            w1_next = WEIGHT_HALF;   // zero denominator
            w2_next = WEIGHT_HALF;
        end
        else if ((state_reg == S_DIV) && div_stat.done)
        begin
            w1_next = div_quot_a;
            w2_next = div_quot_b;
        end
        else
        begin
            w_load = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            held_w1_reg   <= WEIGHT_HALF;
            held_w2_reg   <= WEIGHT_HALF;
            held_gain_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if ((state_reg == S_GAIN_SUM) && latch_op)
            begin
                held_w1_reg   <= w1_reg;
                held_w2_reg   <= w2_reg;
                held_gain_reg <= gain_sat;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            op_reg   <= q_entry.op;
            item_reg <= q_entry.item;
        end
        if (q_pop && (q_entry.op == OP_PASS))
        begin
            res_re_reg   <= q_entry.item.relay_re;
            res_im_reg   <= q_entry.item.relay_im;
            res_gain_reg <= q_entry.item.rd_gain;
        end
        if (q_pop && (q_entry.op == OP_HELD))
        begin
            gain_reg <= held_gain_reg;
        end
        if (state_reg == S_MUL_A)
        begin
            a_reg <= PROD_W'(item_reg.sd_gain) * PROD_W'(cfg.sd_snr);
        end
        if (state_reg == S_MUL_B)
        begin
            b_reg <= PROD_W'(item_reg.rd_gain) * PROD_W'(cfg.rd_snr);
        end
        if (state_reg == S_SUM)
        begin
            d_reg <= {1'b0, a_reg} + {1'b0, b_reg};
        end
        if (w_load)
        begin
            w1_reg <= w1_next;
            w2_reg <= w2_next;
        end
        if (state_reg == S_GAIN_A)
        begin
            pg1_reg <= GP_W'(w1_reg) * GP_W'(item_reg.sd_gain);
        end
        if (state_reg == S_GAIN_B)
        begin
            pg2_reg <= GP_W'(w2_reg) * GP_W'(item_reg.rd_gain);
        end
        if (state_reg == S_GAIN_SUM)
        begin
            gain_reg <= gain_sat;
        end
        if (state_reg == S_SAMP_A)
        begin
            m_re_reg <= MUL_W'(item_reg.src_re) * MUL_W'($signed({1'b0, w1_reg}));
            m_im_reg <= MUL_W'(item_reg.src_im) * MUL_W'($signed({1'b0, w1_reg}));
        end
        if (state_reg == S_SAMP_B)
        begin
            n_re_reg <= MUL_W'(item_reg.relay_re) * MUL_W'($signed({1'b0, w2_reg}));
            n_im_reg <= MUL_W'(item_reg.relay_im) * MUL_W'($signed({1'b0, w2_reg}));
        end
        if (state_reg == S_SAMP_SUM)
        begin
            res_re_reg   <= round_sat(ACC_W'(m_re_reg) + relay_term(n_re_reg, cfg.relay_x4));
            res_im_reg   <= round_sat(ACC_W'(m_im_reg) + relay_term(n_im_reg, cfg.relay_x4));
            res_gain_reg <= gain_reg;
        end
        if (load_out)
        begin
            out_re_reg   <= res_re_reg;
            out_im_reg   <= res_im_reg;
            out_gain_reg <= res_gain_reg;
        end
    end

    assign out_ch.valid         = out_valid_reg;
    assign out_ch.out_re        = out_re_reg;
    assign out_ch.out_im        = out_im_reg;
    assign out_ch.combined_gain = out_gain_reg;

    assign stat.idle     = state_reg == S_IDLE;
    assign stat.wait_div = state_reg == S_DIV;

endmodule

// ----- hdl/two_branch_diversity_combiner_core.sv -----
// Two-branch diversity combiner: weights the direct and relay samples by their
// SNR-scaled channel gains and sums them. An item is one direct sample, one
// relay sample and both gains; each item gives exactly one result, in order.
// Per item, once the back end picks it up: a relay-only item goes straight
// out; an item on held packet weights forms only the weighted sum; an item that
// computes weights (per-sample mode, or the first item of a packet in
// quasi-static mode) first forms the SNR-scaled gains and runs the two 16-step
// restoring dividers side by side. An equal-gain packet start skips them.
// A two-entry queue in front of the sequencer keeps the input accepting while
// a result waits at the output. Weight and SNR registers sit on an APB port at
// byte addresses 4*i and must only be written while no item is in flight.
// Depends on tbdc_pkg, tbdc_in_if, tbdc_out_if, the tbdc_* submodules and
// assert_macros.svh.
`include "assert_macros.svh"

module two_branch_diversity_combiner_core
    import tbdc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // register port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    // item channels
    tbdc_in_if.sink           in_ch,
    tbdc_out_if.source        out_ch
);

    cfg_t                cfg_reg;
    cfg_reg_t            reg_idx;
    logic                wr_en;

    q_stat_t             q_stat;
    logic                q_push, q_pop;
    entry_t              q_push_entry, q_pop_entry;

    div_req_t            div_req;
    div_stat_t           div_stat_a, div_stat_b;
    logic [PROD_W-1:0]   div_num_a, div_num_b;
    logic [WEIGHT_W-1:0] div_quot_a, div_quot_b;
    back_stat_t          back_stat;

    // ---------------------------------------------------------------
    // Register file. Zero-wait APB: the write lands on the access phase.
    // ---------------------------------------------------------------
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = cfg_reg_t'(paddr[ADDR_W-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.per_sample <= 1'b0;
            cfg_reg.equal_gain <= 1'b0;
            cfg_reg.sd_snr     <= SNR_RESET;
            cfg_reg.rd_snr     <= SNR_RESET;
            cfg_reg.relay_x4   <= 1'b0;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_PER_SAMPLE: cfg_reg.per_sample <= pwdata[0];
                REG_EQUAL_GAIN: cfg_reg.equal_gain <= pwdata[0];
                REG_SD_SNR:     cfg_reg.sd_snr     <= pwdata[SNR_W-1:0];
                REG_RD_SNR:     cfg_reg.rd_snr     <= pwdata[SNR_W-1:0];
                REG_RELAY_X4:   cfg_reg.relay_x4   <= pwdata[0];
                default:        ;   // unmapped addresses ignore writes
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_PER_SAMPLE: prdata = DATA_W'(cfg_reg.per_sample);
            REG_EQUAL_GAIN: prdata = DATA_W'(cfg_reg.equal_gain);
            REG_SD_SNR:     prdata = DATA_W'(cfg_reg.sd_snr);
            REG_RD_SNR:     prdata = DATA_W'(cfg_reg.rd_snr);
            REG_RELAY_X4:   prdata = DATA_W'(cfg_reg.relay_x4);
            default:        prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // Front end tags each item (pass, compute, latch, latch equal, held)
    // and pushes it into the queue.
    // ---------------------------------------------------------------
    tbdc_front u_front (
        .cfg     (cfg_reg),
        .q_stat  (q_stat),
        .q_push  (q_push),
        .q_entry (q_push_entry),
        .in_ch   (in_ch)
    );

    tbdc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_push_entry),
        .pop        (q_pop),
        .pop_entry  (q_pop_entry),
        .stat       (q_stat)
    );

    // ---------------------------------------------------------------
    // Back end: one item at a time. w1 and w2 are truncated separately, so
    // two dividers share the denominator and run in parallel.
    // ---------------------------------------------------------------
    tbdc_div u_div_a (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .num   (div_num_a),
        .stat  (div_stat_a),
        .quot  (div_quot_a)
    );

    tbdc_div u_div_b (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .num   (div_num_b),
        .stat  (div_stat_b),
        .quot  (div_quot_b)
    );

    tbdc_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_reg),
        .q_stat     (q_stat),
        .q_entry    (q_pop_entry),
        .q_pop      (q_pop),
        .div_req    (div_req),
        .div_num_a  (div_num_a),
        .div_num_b  (div_num_b),
        .div_stat   (div_stat_a),
        .div_quot_a (div_quot_a),
        .div_quot_b (div_quot_b),
        .stat       (back_stat),
        .out_ch     (out_ch)
    );

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    `ASSERT_IMPL(a_pop_not_empty, clk, rst_n, q_pop, q_stat.valid, "pop from empty item queue")
    `ASSERT_NEVER(a_push_not_full, clk, rst_n, q_push && q_stat.full, "push into full item queue")
    `ASSERT_IMPL(a_div_in_step, clk, rst_n, div_stat_a.done, back_stat.wait_div && div_stat_b.done, "dividers out of step with sequencer")
    `ASSERT_IMPL(a_out_from_seq, clk, rst_n, $rose(out_ch.valid), $past(!back_stat.idle), "result appeared without sequencer work")

endmodule
